[hdl/frr_pkg.sv]
`default_nettype none
package frr_pkg;
  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_SORT  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_t;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 9;
  localparam int OCNT_W = 32;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] symbol_code;
    logic [SYM_W-1:0]  code_symbol;
    logic [OCNT_W-1:0] symbol_count;
    logic [CODE_W-1:0] used_codes;
    logic              sorted_flag;
  } rsp_t;
endpackage
`default_nettype wire

[hdl/frr_if.sv]
`default_nettype none
interface frr_req_if (input wire logic clk);
  logic          valid;
  logic          ready;
  frr_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frr_rsp_if (input wire logic clk);
  logic          valid;
  logic          ready;
  frr_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/frr_front.sv]
`default_nettype none
// Input side: two-entry request queue toward the engine.
module frr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  frr_req_if.sink            in_req,
  output frr_pkg::req_t      q_data,
  output logic               q_valid,
  input  wire logic          q_pop
);
  frr_pkg::req_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_req.ready = (cnt_r != 2'd2);
  assign push    = in_req.valid && in_req.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req.data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

[hdl/frr_back.sv]
`default_nettype none
// Engine: clear sweep, count, rank sort (read then compare), query.
module frr_back #(
  parameter int SYMBOLS    = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire frr_pkg::req_t q_data,
  input  wire logic          q_valid,
  output logic               q_pop,
  frr_rsp_if.source          out_rsp
);
  localparam int IW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CW = IW + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_CNT_WR, ST_SRT_S, ST_SRT_T, ST_SRT_C,
    ST_SRT_WR, ST_Q_RD, ST_Q_OUT
  } state_t;

  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [8:0]            code_mem [SYMBOLS];
  logic [7:0]            sym_mem  [SYMBOLS];

  state_t           st_r;
  logic [CW-1:0]    s_r, t_r;
  logic [8:0]       rank_r, used_r;
  logic             sorted_r;
  logic [COUNT_BITS-1:0] cs_r, ct_r, rd_cnt_r;
  logic [8:0]       rd_code_r;
  logic [7:0]       rd_sym_r;
  logic [7:0]       sym_r;
  logic             out_v_r;
  frr_pkg::rsp_t    out_r;
  logic             in_rng;

  assign in_rng = ({1'b0, q_data.symbol} < 9'(SYMBOLS));
  assign out_rsp.valid = out_v_r;
  assign out_rsp.data  = out_r;
  assign q_pop = (st_r == ST_Q_OUT) && (!out_v_r || out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; s_r <= '0; t_r <= '0; rank_r <= '0; used_r <= '0;
      sorted_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      // ST_Q_OUT sets valid again itself when the old result leaves
      if (out_v_r && out_rsp.ready && st_r != ST_Q_OUT) out_v_r <= 1'b0;
      case (st_r)
        ST_CLEAR: begin
          cnt_mem[s_r[IW-1:0]]  <= '0;
          code_mem[s_r[IW-1:0]] <= '0;
          sym_mem[s_r[IW-1:0]]  <= '0;
          if (s_r == CW'(SYMBOLS - 1)) st_r <= ST_IDLE;
          s_r <= s_r + 1'b1;
        end
        ST_IDLE: if (q_valid) begin
          sym_r <= q_data.symbol;
          if (q_data.command == frr_pkg::CMD_COUNT && in_rng) st_r <= ST_RD;
          else if (q_data.command == frr_pkg::CMD_SORT && !sorted_r) begin
            s_r <= '0; used_r <= '0; st_r <= ST_SRT_S;
          end else st_r <= ST_Q_RD;
        end
        ST_RD: begin
          rd_cnt_r <= cnt_mem[sym_r[IW-1:0]];
          st_r <= ST_CNT_WR;
        end
        ST_CNT_WR: begin
          if (rd_cnt_r != CMAX) cnt_mem[sym_r[IW-1:0]] <= rd_cnt_r + 1'b1;
          st_r <= ST_Q_RD;
        end
        ST_SRT_S: begin
          cs_r <= cnt_mem[s_r[IW-1:0]];
          t_r <= '0; rank_r <= '0;
          st_r <= ST_SRT_T;
        end
        ST_SRT_T: begin
          ct_r <= cnt_mem[t_r[IW-1:0]];
          st_r <= ST_SRT_C;
        end
        ST_SRT_C: begin
          if ((ct_r > cs_r) || (ct_r == cs_r && t_r < s_r)) rank_r <= rank_r + 1'b1;
          if (t_r == CW'(SYMBOLS - 1)) st_r <= ST_SRT_WR;
          else begin
            t_r <= t_r + 1'b1; st_r <= ST_SRT_T;
          end
        end
        ST_SRT_WR: begin
          code_mem[s_r[IW-1:0]] <= rank_r + 9'd1;
          sym_mem[rank_r[IW-1:0]] <= 8'(s_r);
          if (cs_r != '0) used_r <= used_r + 9'd1;
          if (s_r == CW'(SYMBOLS - 1)) begin
            sorted_r <= 1'b1; st_r <= ST_Q_RD;
          end else begin
            s_r <= s_r + 1'b1; st_r <= ST_SRT_S;
          end
        end
        ST_Q_RD: begin
          rd_cnt_r  <= cnt_mem[sym_r[IW-1:0]];
          rd_code_r <= code_mem[sym_r[IW-1:0]];
          rd_sym_r  <= sym_mem[sym_r[IW-1:0]];
          st_r <= ST_Q_OUT;
        end
        ST_Q_OUT: if (!out_v_r || out_rsp.ready) begin
          out_v_r <= 1'b1;
          if ({1'b0, sym_r} < 9'(SYMBOLS)) begin
            out_r.symbol_code  <= rd_code_r;
            out_r.code_symbol  <= rd_sym_r;
            out_r.symbol_count <= 32'(rd_cnt_r);
          end else begin
            out_r.symbol_code <= '0; out_r.code_symbol <= '0;
            out_r.symbol_count <= '0;
          end
          out_r.used_codes  <= used_r;
          out_r.sorted_flag <= sorted_r;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/frequency_rank_remap.sv]
// Accept to result valid: query/other/repeated sort pass the read and output states;
// count first reads and rewrites the single-port histogram; one request at a time.
// First sort: per symbol, a read then a compare against every symbol yields its
// rank; then the query path. A two-entry input queue absorbs bursts.
// Reset: synchronous active-low; then a clearing pass over the tables, during
// which the input queue takes at most two requests.
`default_nettype none
module frequency_rank_remap #(
  parameter int SYMBOLS    = 256,
  parameter int COUNT_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  frr_req_if.sink   in_req,
  frr_rsp_if.source out_rsp
);
  frr_pkg::req_t q_data;
  logic          q_valid, q_pop;

  frr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_req(in_req),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  frr_back #(.SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop), .out_rsp(out_rsp)
  );
endmodule
`default_nettype wire

[hdl/frr_checker.sv]
`default_nettype none
module frr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_sorted,
  input wire logic [8:0] out_used,
  input wire logic [8:0] out_code
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_sorted_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sorted |-> ##1 (!out_valid || out_sorted))
    else $error("sorted flag fell");
  a_unsorted_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sorted |-> out_used == 9'd0 && out_code == 9'd0)
    else $error("codes before sort");
endmodule

bind frequency_rank_remap frr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .out_sorted(out_rsp.data.sorted_flag), .out_used(out_rsp.data.used_codes),
  .out_code(out_rsp.data.symbol_code)
);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  localparam int NSYM      = 256;
  localparam int CODE_W    = frr_pkg::CODE_W;
  localparam int SYM_W     = frr_pkg::SYM_W;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam int LIMIT_CYC = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  frr_req_if in_req (clk);
  frr_rsp_if out_rsp (clk);

  frequency_rank_remap dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the histogram and ranking tables
  logic [31:0]       hist [NSYM];
  logic [CODE_W-1:0] code_tab [NSYM];
  logic [SYM_W-1:0]  sym_tab [NSYM];
  logic [CODE_W-1:0] used_cnt;
  logic              ranked;

  frr_pkg::rsp_t rsp_q [$];
  int   errors = 0;
  int   cycles = 0;
  bit   steady = 1'b0;
  int   hold_reqs = 0;
  int   hold_done = 0;
  int   hold_left = 0;

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", field, got, want, $realtime);
    errors++;
  endtask

  task automatic rank_symbols();
    int rank;
    int used;
    used = 0;
    for (int s = 0; s < NSYM; s++) begin
      rank = 0;
      for (int t = 0; t < NSYM; t++)
        if (t != s && (hist[t] > hist[s] || (hist[t] == hist[s] && t < s)))
          rank++;
      code_tab[s] = CODE_W'(rank + 1);
      sym_tab[rank] = SYM_W'(s);
      if (hist[s] != 0) used++;
    end
    used_cnt = CODE_W'(used);
    ranked = 1'b1;
  endtask

  task automatic predict_rsp(input frr_pkg::req_t r, output frr_pkg::rsp_t e);
    if (r.command == frr_pkg::CMD_COUNT) begin
      if (hist[r.symbol] != CNT_MAX) hist[r.symbol] = hist[r.symbol] + 1;
    end else if (r.command == frr_pkg::CMD_SORT) begin
      if (!ranked) rank_symbols();
    end
    e.symbol_code  = code_tab[r.symbol];
    e.code_symbol  = sym_tab[r.symbol];
    e.symbol_count = hist[r.symbol];
    e.used_codes   = used_cnt;
    e.sorted_flag  = ranked;
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_req(frr_pkg::cmd_t c, logic [SYM_W-1:0] s);
    frr_pkg::req_t r;
    frr_pkg::rsp_t e;
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    r.command = c;
    r.symbol  = s;
    in_req.valid <= 1'b1;
    in_req.data  <= r;
    do @(posedge clk); while (!in_req.ready);
    predict_rsp(r, e);
    rsp_q.push_back(e);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] skewed_sym();
    // bias toward a few symbols so counts spread out and ties remain
    case ($urandom_range(0, 3))
      0: return SYM_W'($urandom_range(0, 255));
      1: return SYM_W'($urandom_range(0, 7));
      2: return SYM_W'($urandom_range(0, 31) * 8);
      default: return SYM_W'($urandom_range(240, 255));
    endcase
  endfunction

  function automatic frr_pkg::cmd_t rand_cmd(bit allow_sort);
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return frr_pkg::CMD_COUNT;
    if (p < 85) return frr_pkg::CMD_QUERY;
    if (p < 95 || !allow_sort) return frr_pkg::CMD_OTHER;
    return frr_pkg::CMD_SORT;
  endfunction

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_rsp.ready <= 1'b0;
      hold_left <= 300;
      hold_done <= hold_done + 1;
    end else begin
      out_rsp.ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin
    frr_pkg::rsp_t got;
    frr_pkg::rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = out_rsp.data;
      if (rsp_q.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = rsp_q.pop_front();
        if (got.symbol_code !== want.symbol_code)
          report_mismatch("symbol_code", got.symbol_code, want.symbol_code);
        if (got.code_symbol !== want.code_symbol)
          report_mismatch("code_symbol", got.code_symbol, want.code_symbol);
        if (got.symbol_count !== want.symbol_count)
          report_mismatch("symbol_count", got.symbol_count, want.symbol_count);
        if (got.used_codes !== want.used_codes)
          report_mismatch("used_codes", got.used_codes, want.used_codes);
        if (got.sorted_flag !== want.sorted_flag)
          report_mismatch("sorted_flag", got.sorted_flag, want.sorted_flag);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYC) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_unsorted_edges();
    send_req(frr_pkg::CMD_QUERY, 8'd0);
    send_req(frr_pkg::CMD_QUERY, 8'd255);
    send_req(frr_pkg::CMD_COUNT, 8'd0);
    send_req(frr_pkg::CMD_COUNT, 8'd255);
    send_req(frr_pkg::CMD_COUNT, 8'd255);
    send_req(frr_pkg::CMD_OTHER, 8'd255);
    send_req(frr_pkg::CMD_OTHER, 8'd0);
    send_req(frr_pkg::CMD_QUERY, 8'hAA);
    send_req(frr_pkg::CMD_COUNT, 8'h55);
    send_req(frr_pkg::CMD_QUERY, 8'h55);
    send_req(frr_pkg::CMD_COUNT, 8'd1);
    send_req(frr_pkg::CMD_COUNT, 8'd2);
    send_req(frr_pkg::CMD_COUNT, 8'd2);
    drain();
  endtask

  task automatic test_histogram_fill(int n);
    steady = 1'b1;
    for (int i = 0; i < n / 4; i++) send_req(rand_cmd(1'b0), skewed_sym());
    steady = 1'b0;
    hold_reqs++;
    for (int i = 0; i < n - n / 4; i++) send_req(rand_cmd(1'b0), skewed_sym());
    drain();
  endtask

  task automatic test_rank_once();
    send_req(frr_pkg::CMD_SORT, 8'd0);
    send_req(frr_pkg::CMD_SORT, 8'd255);
    send_req(frr_pkg::CMD_QUERY, 8'd0);
    send_req(frr_pkg::CMD_QUERY, 8'd255);
    send_req(frr_pkg::CMD_COUNT, 8'd255);
    send_req(frr_pkg::CMD_OTHER, 8'd128);
    drain();
  endtask

  task automatic test_after_rank(int n);
    hold_reqs++;
    for (int i = 0; i < n; i++) begin
      send_req(rand_cmd(1'b1), $urandom_range(0, 1) ? skewed_sym()
                                                   : SYM_W'($urandom_range(0, 255)));
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NSYM; i++) begin
      hist[i] = '0;
      code_tab[i] = '0;
      sym_tab[i] = '0;
    end
    used_cnt = '0;
    ranked = 1'b0;
    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unsorted_edges();
    test_histogram_fill(1000);
    test_rank_once();
    test_after_rank(1000);
    repeat (50) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
